/* hdl/convex_polygon_gjk_test_assert.svh */
// assertion macros for the gjk intersection block
`ifndef CONVEX_POLYGON_GJK_TEST_ASSERT_SVH
`define CONVEX_POLYGON_GJK_TEST_ASSERT_SVH

`ifndef SYNTHESIS
`define CGJK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gjk assertion failed");
`define CGJK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gjk assertion failed");
`else
`define CGJK_ASSERT_IMPL(lbl, ante, cons)
`define CGJK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/cgjk_pkg.sv */
// shared constants and types for the gjk intersection block
`timescale 1ns / 1ps
`default_nettype none
package cgjk_pkg;

  localparam int MaxVerts = 16;
  localparam int MaxIter  = 32;
  localparam int CoordW   = 16;
  localparam int PtW      = CoordW + 1;
  localparam int DiffW    = CoordW + 2;
  localparam int DotVW    = CoordW + 3;
  localparam int DirW     = 56;
  localparam int HalfW    = DirW / 2;
  localparam int MulAW    = 38;
  localparam int MulBW    = DotVW;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 88;
  localparam int TripW    = 2 * DiffW + 1;
  localparam int IdxW     = $clog2(MaxVerts);
  localparam int CntW     = $clog2(MaxVerts + 1);
  localparam int IterW    = $clog2(MaxIter + 1);
  localparam int VertW    = 2 * CoordW;

  localparam logic [1:0] FuncClear = 2'd0;
  localparam logic [1:0] FuncAddA  = 2'd1;
  localparam logic [1:0] FuncAddB  = 2'd2;
  localparam logic [1:0] FuncTest  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StLimit = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    logic shl;
  } mac_op_t;

endpackage
`default_nettype wire

/* hdl/convex_polygon_gjk_test.sv */
// gjk intersection test for two convex polygons, top level and sequencer
//
// input channel (in_valid_i / in_ready_o) takes one request: func_i selects
// clear, add vertex to polygon a, add vertex to polygon b, or run the test;
// vertex_x_i / vertex_y_i carry the vertex for the two add requests.
// output channel (out_valid_o / out_ready_i) returns intersect_res_o and
// status_o for a test request and for an add to a full polygon; clear and
// accepted adds give nothing back.
// clear and add are handled in the idle state. a test runs on one shared
// multiply-accumulate unit: each support point scans every vertex of both
// polygons, then come the support check and a simplex refinement; a test
// runs at most 32 gjk iterations plus the first support point.
// the input is not ready while a test or a pending result is in progress.
// a finished result sits in the output register; the next request is taken
// while it waits, and a further result waits until the receiver takes it.
// reset empties both polygons and the output register.
`timescale 1ns / 1ps
`default_nettype none
module convex_polygon_gjk_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic signed [cgjk_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [cgjk_pkg::CoordW-1:0] vertex_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               intersect_res_o,
  output logic [1:0]                         status_o
);
  import cgjk_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TST   = 4'd1;
  localparam logic [3:0] S_INIT0 = 4'd2;
  localparam logic [3:0] S_INIT1 = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_LD    = 4'd5;
  localparam logic [3:0] S_DOT   = 4'd6;
  localparam logic [3:0] S_DEND  = 4'd7;
  localparam logic [3:0] S_SUPD  = 4'd8;
  localparam logic [3:0] S_ITER  = 4'd9;
  localparam logic [3:0] S_REF   = 4'd10;
  localparam logic [3:0] S_TRI   = 4'd11;
  localparam logic [3:0] S_TEND  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam logic [1:0] CtxScan  = 2'd0;
  localparam logic [1:0] CtxStest = 2'd1;
  localparam logic [1:0] CtxPt1   = 2'd2;
  localparam logic [1:0] CtxPt2   = 2'd3;

  localparam logic [1:0] TcSeg = 2'd0;
  localparam logic [1:0] TcT3a = 2'd1;
  localparam logic [1:0] TcT3b = 2'd2;

  logic [3:0]             state_q;
  logic [CntW-1:0]        cnt_a_q, cnt_b_q;
  logic [IdxW-1:0]        idx_q;
  logic                   sel_q;
  logic                   init_q;
  logic                   dsel_q;
  logic [1:0]             ctx_q, tctx_q;
  logic [3:0]             k_q;
  logic [IterW-1:0]       iter_q;
  logic [1:0]             scnt_q;
  logic signed [DirW-1:0] dir_x_q, dir_y_q, p_x_q, p_y_q;
  logic signed [PtW-1:0]  s_px_q [3];
  logic signed [PtW-1:0]  s_py_q [3];
  logic signed [DotVW-1:0] dv_x_q, dv_y_q;
  logic signed [AccW-1:0] bd_q;
  logic signed [CoordW-1:0] ba_x_q, ba_y_q, bb_x_q, bb_y_q;
  logic signed [DiffW-1:0] ta_x_q, ta_y_q, tb_x_q, tb_y_q, tc_x_q, tc_y_q;
  logic signed [TripW-1:0] tac_q, tbc_q;
  logic                   pend_hit_q;
  logic [1:0]             pend_st_q;
  logic                   out_valid_q, res_hit_q;
  logic [1:0]             res_st_q;

  logic                   accept;
  logic                   we_a, we_b;
  logic [VertW-1:0]       wdata;
  logic [VertW-1:0]       rd_a, rd_b, rd_v;
  logic signed [PtW-1:0]  sup_x, sup_y;
  logic [CntW-1:0]        cur_cnt;
  logic signed [DirW-1:0] dd_x, dd_y;
  logic signed [AccW-1:0] acc;
  logic                   acc_neg, acc_zero, better;
  mac_op_t                mop;
  logic signed [MulAW-1:0] mac_a;
  logic signed [MulBW-1:0] mac_b;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign we_a = accept && (func_i == FuncAddA) && (cnt_a_q < CntW'(MaxVerts));
  assign we_b = accept && (func_i == FuncAddB) && (cnt_b_q < CntW'(MaxVerts));
  assign wdata = {vertex_x_i, vertex_y_i};

  cgjk_vmem u_mem_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rd_a)
  );

  cgjk_vmem u_mem_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rd_b)
  );

  cgjk_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mop),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign rd_v     = sel_q ? rd_b : rd_a;
  assign sup_x    = PtW'(ba_x_q) - PtW'(bb_x_q);
  assign sup_y    = PtW'(ba_y_q) - PtW'(bb_y_q);
  assign cur_cnt  = sel_q ? cnt_b_q : cnt_a_q;
  assign dd_x     = dsel_q ? p_x_q : dir_x_q;
  assign dd_y     = dsel_q ? p_y_q : dir_y_q;
  assign acc_neg  = acc[AccW-1];
  assign acc_zero = (acc == '0);
  assign better   = (idx_q == '0) || (sel_q ? (acc < bd_q) : (acc > bd_q));

  // operand selection for the shared unit
  always_comb begin
    mop   = '0;
    mac_a = '0;
    mac_b = '0;
    if (state_q == S_DOT) begin
      mop.en  = 1'b1;
      mop.clr = (k_q[1:0] == 2'd0);
      mop.shl = !k_q[0];
      case (k_q[1:0])
        2'd0: begin
          mac_a = MulAW'($signed(dd_x[DirW-1:HalfW]));
          mac_b = dv_x_q;
        end
        2'd1: begin
          mac_a = MulAW'($signed({1'b0, dd_x[HalfW-1:0]}));
          mac_b = dv_x_q;
        end
        2'd2: begin
          mac_a = MulAW'($signed(dd_y[DirW-1:HalfW]));
          mac_b = dv_y_q;
        end
        default: begin
          mac_a = MulAW'($signed({1'b0, dd_y[HalfW-1:0]}));
          mac_b = dv_y_q;
        end
      endcase
    end else if (state_q == S_TRI && !k_q[3]) begin
      mop.en  = 1'b1;
      mop.clr = !k_q[0];
      mop.sub = (k_q[2:0] == 3'd5) || (k_q[2:0] == 3'd7);
      case (k_q[2:0])
        3'd0: begin mac_a = MulAW'(tc_x_q); mac_b = MulBW'(ta_x_q); end
        3'd1: begin mac_a = MulAW'(tc_y_q); mac_b = MulBW'(ta_y_q); end
        3'd2: begin mac_a = MulAW'(tc_x_q); mac_b = MulBW'(tb_x_q); end
        3'd3: begin mac_a = MulAW'(tc_y_q); mac_b = MulBW'(tb_y_q); end
        3'd4: begin mac_a = MulAW'(tac_q);  mac_b = MulBW'(tb_x_q); end
        3'd5: begin mac_a = MulAW'(tbc_q);  mac_b = MulBW'(ta_x_q); end
        3'd6: begin mac_a = MulAW'(tac_q);  mac_b = MulBW'(tb_y_q); end
        default: begin mac_a = MulAW'(tbc_q); mac_b = MulBW'(ta_y_q); end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      idx_q   <= '0;
      sel_q   <= 1'b0;
      init_q  <= 1'b0;
      dsel_q  <= 1'b0;
      ctx_q   <= CtxScan;
      tctx_q  <= TcSeg;
      k_q     <= '0;
      iter_q  <= '0;
      scnt_q  <= '0;
      dir_x_q <= '0;
      dir_y_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (func_i)
              FuncClear: begin
                cnt_a_q <= '0;
                cnt_b_q <= '0;
              end
              FuncAddA: begin
                if (we_a) begin
                  cnt_a_q <= cnt_a_q + 1'b1;
                end else begin
                  pend_hit_q <= 1'b0;
                  pend_st_q  <= StFull;
                  state_q    <= S_OUT;
                end
              end
              FuncAddB: begin
                if (we_b) begin
                  cnt_b_q <= cnt_b_q + 1'b1;
                end else begin
                  pend_hit_q <= 1'b0;
                  pend_st_q  <= StFull;
                  state_q    <= S_OUT;
                end
              end
              default: state_q <= S_TST;
            endcase
          end
        end
        S_TST: begin
          if (cnt_a_q == '0 || cnt_b_q == '0) begin
            pend_hit_q <= 1'b0;
            pend_st_q  <= StEmpty;
            state_q    <= S_OUT;
          end else begin
            idx_q   <= '0;
            sel_q   <= 1'b0;
            state_q <= S_INIT0;
          end
        end
        S_INIT0: state_q <= S_INIT1;
        S_INIT1: begin
          dir_x_q <= DirW'($signed(rd_a[VertW-1:CoordW]));
          dir_y_q <= DirW'($signed(rd_a[CoordW-1:0]));
          init_q  <= 1'b1;
          dsel_q  <= 1'b0;
          state_q <= S_RD;
        end
        S_RD: state_q <= S_LD;
        S_LD: begin
          dv_x_q  <= DotVW'($signed(rd_v[VertW-1:CoordW]));
          dv_y_q  <= DotVW'($signed(rd_v[CoordW-1:0]));
          ctx_q   <= CtxScan;
          k_q     <= '0;
          state_q <= S_DOT;
        end
        S_DOT: begin
          k_q <= k_q + 1'b1;
          if (k_q[1:0] == 2'd3) begin
            state_q <= S_DEND;
          end
        end
        S_DEND: begin
          case (ctx_q)
            CtxScan: begin
              if (better) begin
                bd_q <= acc;
                if (sel_q) begin
                  bb_x_q <= dv_x_q[CoordW-1:0];
                  bb_y_q <= dv_y_q[CoordW-1:0];
                end else begin
                  ba_x_q <= dv_x_q[CoordW-1:0];
                  ba_y_q <= dv_y_q[CoordW-1:0];
                end
              end
              if (CntW'(idx_q) + 1'b1 < cur_cnt) begin
                idx_q   <= idx_q + 1'b1;
                state_q <= S_RD;
              end else if (!sel_q) begin
                sel_q   <= 1'b1;
                idx_q   <= '0;
                state_q <= S_RD;
              end else begin
                state_q <= S_SUPD;
              end
            end
            CtxStest: begin
              if (acc_neg || acc_zero) begin
                pend_hit_q <= 1'b0;
                pend_st_q  <= StOk;
                state_q    <= S_OUT;
              end else begin
                s_px_q[scnt_q] <= sup_x;
                s_py_q[scnt_q] <= sup_y;
                scnt_q  <= scnt_q + 1'b1;
                state_q <= S_REF;
              end
            end
            CtxPt1: begin
              if (!acc_neg) begin
                dir_x_q   <= p_x_q;
                dir_y_q   <= p_y_q;
                s_px_q[1] <= s_px_q[2];
                s_py_q[1] <= s_py_q[2];
                scnt_q    <= 2'd2;
                state_q   <= S_ITER;
              end else begin
                ta_x_q  <= tb_x_q;
                ta_y_q  <= tb_y_q;
                tb_x_q  <= ta_x_q;
                tb_y_q  <= ta_y_q;
                tc_x_q  <= ta_x_q;
                tc_y_q  <= ta_y_q;
                tctx_q  <= TcT3b;
                k_q     <= '0;
                state_q <= S_TRI;
              end
            end
            default: begin
              if (acc_neg) begin
                pend_hit_q <= 1'b1;
                pend_st_q  <= StOk;
                state_q    <= S_OUT;
              end else begin
                dir_x_q   <= p_x_q;
                dir_y_q   <= p_y_q;
                s_px_q[0] <= s_px_q[1];
                s_py_q[0] <= s_py_q[1];
                s_px_q[1] <= s_px_q[2];
                s_py_q[1] <= s_py_q[2];
                scnt_q    <= 2'd2;
                state_q   <= S_ITER;
              end
            end
          endcase
        end
        S_SUPD: begin
          if (init_q) begin
            s_px_q[0] <= sup_x;
            s_py_q[0] <= sup_y;
            scnt_q    <= 2'd1;
            dir_x_q   <= -DirW'(sup_x);
            dir_y_q   <= -DirW'(sup_y);
            init_q    <= 1'b0;
            iter_q    <= '0;
            state_q   <= S_ITER;
          end else begin
            dv_x_q  <= DotVW'(sup_x);
            dv_y_q  <= DotVW'(sup_y);
            dsel_q  <= 1'b0;
            ctx_q   <= CtxStest;
            k_q     <= '0;
            state_q <= S_DOT;
          end
        end
        S_ITER: begin
          if (iter_q == IterW'(MaxIter)) begin
            pend_hit_q <= 1'b0;
            pend_st_q  <= StLimit;
            state_q    <= S_OUT;
          end else begin
            iter_q  <= iter_q + 1'b1;
            idx_q   <= '0;
            sel_q   <= 1'b0;
            dsel_q  <= 1'b0;
            state_q <= S_RD;
          end
        end
        S_REF: begin
          k_q     <= '0;
          state_q <= S_TRI;
          if (scnt_q == 2'd2) begin
            ta_x_q <= DiffW'(s_px_q[0]) - DiffW'(s_px_q[1]);
            ta_y_q <= DiffW'(s_py_q[0]) - DiffW'(s_py_q[1]);
            tc_x_q <= DiffW'(s_px_q[0]) - DiffW'(s_px_q[1]);
            tc_y_q <= DiffW'(s_py_q[0]) - DiffW'(s_py_q[1]);
            tb_x_q <= -DiffW'(s_px_q[1]);
            tb_y_q <= -DiffW'(s_py_q[1]);
            tctx_q <= TcSeg;
          end else begin
            ta_x_q <= DiffW'(s_px_q[1]) - DiffW'(s_px_q[2]);
            ta_y_q <= DiffW'(s_py_q[1]) - DiffW'(s_py_q[2]);
            tb_x_q <= DiffW'(s_px_q[0]) - DiffW'(s_px_q[2]);
            tb_y_q <= DiffW'(s_py_q[0]) - DiffW'(s_py_q[2]);
            tc_x_q <= DiffW'(s_px_q[0]) - DiffW'(s_px_q[2]);
            tc_y_q <= DiffW'(s_py_q[0]) - DiffW'(s_py_q[2]);
            tctx_q <= TcT3a;
          end
        end
        S_TRI: begin
          k_q <= k_q + 1'b1;
          case (k_q)
            4'd2: tac_q <= acc[TripW-1:0];
            4'd4: tbc_q <= acc[TripW-1:0];
            4'd6: p_x_q <= acc[DirW-1:0];
            4'd8: begin
              p_y_q   <= acc[DirW-1:0];
              state_q <= S_TEND;
            end
            default: ;
          endcase
        end
        S_TEND: begin
          case (tctx_q)
            TcSeg: begin
              if (p_x_q == '0 && p_y_q == '0) begin
                dir_x_q <= DirW'(ta_y_q);
                dir_y_q <= -DirW'(ta_x_q);
              end else begin
                dir_x_q <= p_x_q;
                dir_y_q <= p_y_q;
              end
              state_q <= S_ITER;
            end
            default: begin
              dv_x_q  <= -DotVW'(s_px_q[2]);
              dv_y_q  <= -DotVW'(s_py_q[2]);
              dsel_q  <= 1'b1;
              ctx_q   <= (tctx_q == TcT3a) ? CtxPt1 : CtxPt2;
              k_q     <= '0;
              state_q <= S_DOT;
            end
          endcase
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
      res_hit_q   <= pend_hit_q;
      res_st_q    <= pend_st_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign intersect_res_o = res_hit_q;
  assign status_o        = res_st_q;

`include "convex_polygon_gjk_test_assert.svh"

  `CGJK_ASSERT_IMPL(a_cnt_a_max, 1'b1, cnt_a_q <= CntW'(MaxVerts))
  `CGJK_ASSERT_IMPL(a_cnt_b_max, 1'b1, cnt_b_q <= CntW'(MaxVerts))
  `CGJK_ASSERT_IMPL(a_ref_scnt, state_q == S_REF, scnt_q == 2'd2 || scnt_q == 2'd3)
  `CGJK_ASSERT_NEXT(a_hit_ok, state_q == S_OUT && pend_hit_q && (!out_valid_q || out_ready_i), res_st_q == StOk && out_valid_q)

endmodule
`default_nettype wire

/* hdl/cgjk_vmem.sv */
// vertex store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module cgjk_vmem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [cgjk_pkg::IdxW-1:0]   waddr_i,
  input  logic [cgjk_pkg::VertW-1:0]  wdata_i,
  input  logic [cgjk_pkg::IdxW-1:0]   raddr_i,
  output logic [cgjk_pkg::VertW-1:0]  rdata_o
);
  import cgjk_pkg::*;

  logic [VertW-1:0] mem [MaxVerts];
  logic [VertW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* hdl/cgjk_mac.sv */
// shared signed multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none
module cgjk_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cgjk_pkg::mac_op_t                 op_i,
  input  logic signed [cgjk_pkg::MulAW-1:0] a_i,
  input  logic signed [cgjk_pkg::MulBW-1:0] b_i,
  output logic signed [cgjk_pkg::AccW-1:0]  acc_o
);
  import cgjk_pkg::*;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  acc_d, acc_q;

  always_comb begin
    prod = a_i * b_i;
    term = AccW'(prod);
    if (op_i.shl) begin
      term = term <<< HalfW;
    end
    base  = op_i.clr ? '0 : acc_q;
    acc_d = op_i.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

/* tb/tb_convex_polygon_gjk_test.sv */
// self-checking testbench for the gjk polygon intersection block
`timescale 1ns / 1ps
module tb_convex_polygon_gjk_test;
  import cgjk_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]               func;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } request_t;

  typedef struct {
    logic       hit;
    logic [1:0] status;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FuncClear;
  logic signed [CoordW-1:0] vx = '0;
  logic signed [CoordW-1:0] vy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit_o;
  logic [1:0] status_o;

  request_t pending_reqs[$];
  verdict_t verdicts_due[$];
  int errors = 0;
  int n_tests = 0;
  int n_hits = 0;
  int n_limits = 0;
  int n_full = 0;
  int in_gap = 0;
  int out_gap = 0;

  // predictor state
  longint pax[MaxVerts], pay[MaxVerts], pbx[MaxVerts], pby[MaxVerts];
  int cnt_a = 0, cnt_b = 0;
  longint spx[3], spy[3];
  int s_cnt;
  longint dir_x, dir_y;

  convex_polygon_gjk_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .vertex_x_i     (vx),
    .vertex_y_i     (vy),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .intersect_res_o(hit_o),
    .status_o       (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic wide_t wmul(longint a, longint b);
    wide_t p, q;
    p = a;
    q = b;
    return p * q;
  endfunction

  function automatic wide_t wdot(longint ax, longint ay, longint bx, longint by);
    return wmul(ax, bx) + wmul(ay, by);
  endfunction

  function automatic bit fits_dir(wide_t w);
    wide_t lim;
    lim = 1;
    lim = lim <<< (DirW - 1);
    return (w < lim) && (w >= -lim);
  endfunction

  // b*(a.c) - a*(b.c), squeezed into the direction width
  function automatic void triple_dir(input longint ax, ay, bx, by, cx, cy,
                                     output longint rx, ry);
    longint ac, bc;
    wide_t wx, wy;
    ac = ax * cx + ay * cy;
    bc = bx * cx + by * cy;
    wx = wmul(bx, ac) - wmul(ax, bc);
    wy = wmul(by, ac) - wmul(ay, bc);
    for (int n = 0; n < 128 && !(fits_dir(wx) && fits_dir(wy)); n++) begin
      wx = wx >>> 1;
      wy = wy >>> 1;
    end
    rx = wx[63:0];
    ry = wy[63:0];
  endfunction

  function automatic int far_vertex(bit poly_b, longint dx, longint dy);
    int best, n;
    wide_t bd, d;
    best = 0;
    n = poly_b ? cnt_b : cnt_a;
    bd = poly_b ? wdot(pbx[0], pby[0], dx, dy) : wdot(pax[0], pay[0], dx, dy);
    for (int i = 1; i < n; i++) begin
      d = poly_b ? wdot(pbx[i], pby[i], dx, dy) : wdot(pax[i], pay[i], dx, dy);
      if (d > bd) begin
        best = i;
        bd = d;
      end
    end
    return best;
  endfunction

  function automatic void support_pt(input longint dx, dy, output longint sx, sy);
    int ia, ib;
    ia = far_vertex(1'b0, dx, dy);
    ib = far_vertex(1'b1, -dx, -dy);
    sx = pax[ia] - pbx[ib];
    sy = pay[ia] - pby[ib];
  endfunction

  function automatic bit refine_simplex();
    longint abx, aby, acx, acy, px, py;
    if (s_cnt == 2) begin
      abx = spx[0] - spx[1];
      aby = spy[0] - spy[1];
      triple_dir(abx, aby, -spx[1], -spy[1], abx, aby, dir_x, dir_y);
      // degenerate segment: take the edge perpendicular
      if (dir_x == 0 && dir_y == 0) begin
        dir_x = aby;
        dir_y = -abx;
      end
    end else if (s_cnt == 3) begin
      abx = spx[1] - spx[2];
      aby = spy[1] - spy[2];
      acx = spx[0] - spx[2];
      acy = spy[0] - spy[2];
      triple_dir(abx, aby, acx, acy, acx, acy, px, py);
      if (wdot(px, py, -spx[2], -spy[2]) >= 0) begin
        dir_x = px;
        dir_y = py;
      end else begin
        triple_dir(acx, acy, abx, aby, abx, aby, px, py);
        if (wdot(px, py, -spx[2], -spy[2]) < 0) return 1'b1;
        spx[0] = spx[1];
        spy[0] = spy[1];
        dir_x = px;
        dir_y = py;
      end
      spx[1] = spx[2];
      spy[1] = spy[2];
      s_cnt = 2;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t gjk_verdict();
    verdict_t v;
    longint sx, sy;
    v.hit = 1'b0;
    v.status = StLimit;
    if (cnt_a == 0 || cnt_b == 0) begin
      v.status = StEmpty;
      return v;
    end
    support_pt(pax[0], pay[0], sx, sy);
    spx[0] = sx;
    spy[0] = sy;
    s_cnt = 1;
    dir_x = -sx;
    dir_y = -sy;
    for (int it = 0; it < MaxIter; it++) begin
      support_pt(dir_x, dir_y, sx, sy);
      if (wdot(sx, sy, dir_x, dir_y) <= 0 || s_cnt > 2) begin
        v.status = StOk;
        return v;
      end
      spx[s_cnt] = sx;
      spy[s_cnt] = sy;
      s_cnt++;
      if (refine_simplex()) begin
        v.hit = 1'b1;
        v.status = StOk;
        return v;
      end
    end
    return v;
  endfunction

  function automatic void predict(request_t r);
    verdict_t v;
    case (r.func)
      FuncClear: begin
        cnt_a = 0;
        cnt_b = 0;
      end
      FuncAddA, FuncAddB: begin
        if ((r.func == FuncAddA ? cnt_a : cnt_b) >= MaxVerts) begin
          v.hit = 1'b0;
          v.status = StFull;
          verdicts_due.push_back(v);
          n_full++;
        end else if (r.func == FuncAddA) begin
          pax[cnt_a] = r.x;
          pay[cnt_a] = r.y;
          cnt_a++;
        end else begin
          pbx[cnt_b] = r.x;
          pby[cnt_b] = r.y;
          cnt_b++;
        end
      end
      default: begin
        v = gjk_verdict();
        verdicts_due.push_back(v);
        n_tests++;
        if (v.hit) n_hits++;
        if (v.status == StLimit) n_limits++;
      end
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    if (errors <= 40) $display("error: %s got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t r;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r.func = func;
        r.x = vx;
        r.y = vy;
        predict(r);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          func <= r.func;
          vx <= r.x;
          vy <= r.y;
          if (pending_reqs.size() > 60 && $urandom_range(0, 7) == 0)
            in_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          report("unexpected result, status", status_o, -1);
        end else begin
          w = verdicts_due.pop_front();
          if (hit_o !== w.hit) report("intersect_res", hit_o, w.hit);
          if (status_o !== w.status) report("status", status_o, w.status);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (pending_reqs.size() > 60 && $urandom_range(0, 7) == 0)
          out_gap = $urandom_range(1, 15);
      end
    end
  end

  task automatic push(logic [1:0] f, int x, int y);
    request_t r;
    r.func = f;
    r.x = CoordW'(x);
    r.y = CoordW'(y);
    pending_reqs.push_back(r);
  endtask

  task automatic push_poly(logic [1:0] f, int cx, int cy, int rad, int k);
    real ph, a;
    int x, y;
    ph = $urandom_range(0, 628) / 100.0;
    for (int i = 0; i < k; i++) begin
      a = ph + 6.2831853 * i / k;
      x = cx + $rtoi(rad * $cos(a));
      y = cy + $rtoi(rad * $sin(a));
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      push(f, x, y);
    end
  endtask

  task automatic push_scene();
    int spread, rad_a, rad_b, ka, kb;
    bit wide;
    wide = ($urandom_range(0, 9) == 0);
    spread = wide ? 16000 : 1500;
    rad_a = $urandom_range(1, wide ? 16000 : 1000);
    rad_b = $urandom_range(1, wide ? 16000 : 1000);
    ka = ($urandom_range(0, 15) == 0) ? MaxVerts : $urandom_range(1, 6);
    kb = ($urandom_range(0, 15) == 0) ? MaxVerts : $urandom_range(1, 6);
    push(FuncClear, $urandom, $urandom);
    push_poly(FuncAddA, $urandom_range(0, 2 * spread) - spread,
              $urandom_range(0, 2 * spread) - spread, rad_a, ka);
    push_poly(FuncAddB, $urandom_range(0, 2 * spread) - spread,
              $urandom_range(0, 2 * spread) - spread, rad_b, kb);
    push(FuncTest, $urandom, $urandom);
    if ($urandom_range(0, 9) == 0) push(FuncAddA, $urandom, $urandom);
    if ($urandom_range(0, 9) == 0) push(FuncTest, $urandom, $urandom);
  endtask

  initial begin
    int n0;
    // empty polygons
    push(FuncTest, 0, 0);
    push(FuncAddA, 32767, -32768);
    push(FuncTest, 0, 0);
    // touching squares
    push(FuncClear, 0, 0);
    push(FuncAddA, 0, 0);
    push(FuncAddA, 10, 0);
    push(FuncAddA, 10, 10);
    push(FuncAddA, 0, 10);
    push(FuncAddB, 10, 0);
    push(FuncAddB, 20, 0);
    push(FuncAddB, 20, 10);
    push(FuncAddB, 10, 10);
    push(FuncTest, 0, 0);
    // overlap at extreme coordinates
    push(FuncAddB, -32768, -32768);
    push(FuncAddB, 32767, 32767);
    push(FuncTest, 0, 0);
    // coincident single points and collinear segment through origin
    push(FuncClear, 0, 0);
    push(FuncAddA, -32768, 32767);
    push(FuncAddB, -32768, 32767);
    push(FuncTest, 0, 0);
    push(FuncAddA, 32767, -32768);
    push(FuncTest, 0, 0);
    // polygon full
    for (int i = 0; i < MaxVerts; i++) push(FuncAddB, i * 1000, -i * 7);
    push(FuncAddB, 1, 1);
    push(FuncTest, 0, 0);
    n0 = pending_reqs.size();
    while (pending_reqs.size() < n0 + 550) begin
      if ($urandom_range(0, 9) < 8) push_scene();
      else push(2'($urandom_range(0, 3)), $urandom, $urandom);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid && verdicts_due.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("ran %0d tests (%0d overlapping, %0d at iteration limit), %0d full-polygon drops",
             n_tests, n_hits, n_limits, n_full);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("convex_polygon_gjk_test: match");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, verdicts_due.size());
      $display("convex_polygon_gjk_test: mismatch");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("timeout");
    $display("convex_polygon_gjk_test: mismatch");
    $finish;
  end

endmodule
